[hdl/assert_macros.svh]
// assertion macros used by indexed_min_heap_queue
// depends on signals named clk and rst in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define HMQ_ASSERT(lbl, prop, msg)
`define HMQ_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

[hdl/hmq_pkg.sv]
// types, codes and defaults of the indexed min-heap queue
// no dependencies
package hmq_pkg;
  localparam int HANDLE_BITS      = 6;
  localparam int HANDLES          = 64;
  localparam int DEFAULT_CAPACITY = 64;
  localparam int DEFAULT_KEY_BITS = 32;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_POP    = 3'd2,
    CMD_PEEK   = 3'd3,
    CMD_REKEY  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  handle;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  out_handle;
    logic [31:0] out_key;
    logic [6:0]  entry_count;
  } res_t;
endpackage

[hdl/hmq_heap_ram.sv]
// heap slot memory: one write port, two registered read ports
// no dependencies
module hmq_heap_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 38,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra0,
  input  logic [AW-1:0]    ra1,
  output logic [WIDTH-1:0] rd0,
  output logic [WIDTH-1:0] rd1
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end
endmodule

[hdl/indexed_min_heap_queue.sv]
// indexed binary min-heap priority queue, top level
// depends on hmq_pkg, hmq_heap_ram and assert_macros.svh
//
// usage:
// - request channel req / req_valid / req_stall carries command, handle, key
// - response channel res / res_valid / res_stall returns status, out_handle,
//   out_key and entry_count, exactly one response per request
// - one request is worked on at a time; req_stall is high while busy and the
//   next request is taken in the cycle after the response is loaded
// - errors and unused commands go straight to the done step; peek reads the
//   root slot and answers from it
// - insert: the new entry climbs from the last slot, a parent read and compare
//   per level, then a final write of the entry and its slot
// - remove and pop: a lookup (remove only) and refill read, then the refill
//   entry climbs or descends level by level; rekey adds the insert walk
// - the rate is set by the sift loop: each level is a read of the heap slot
//   memory, a key compare and a write back
// - reset clears the entry count and the presence flags at once; no clearing
//   pass runs, the memories are only read where they were written
// - a response waiting under res_stall holds; a new request may still be
//   accepted and is worked on, its response waits until the register frees
module indexed_min_heap_queue #(
  parameter int CAPACITY = hmq_pkg::DEFAULT_CAPACITY,
  parameter int KEY_BITS = hmq_pkg::DEFAULT_KEY_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  hmq_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output hmq_pkg::res_t res
);
  import hmq_pkg::*;
  `include "assert_macros.svh"

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = CW + 1;
  localparam int KW = (KEY_BITS > 32) ? 32 : KEY_BITS;
  localparam int EW = HANDLE_BITS + KW;

  // heap entry: handle and its key, kept together per slot
  typedef struct packed {
    logic [HANDLE_BITS-1:0] h;
    logic [KW-1:0]          k;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_POS, S_RD_DEL, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_FINAL, S_DONE
  } state_t;

  state_t                 state;
  cmd_t                   cmd_r;
  logic [HANDLE_BITS-1:0] h_r;
  logic [KW-1:0]          key_r;
  logic [CW-1:0]          count;
  logic [HANDLES-1:0]     present;
  logic [SW-1:0]          p;
  ent_t                   cur;
  logic                   from_del;
  logic                   rekey_pend;
  status_t                rs_status;
  logic [HANDLE_BITS-1:0] rs_handle;
  logic [KW-1:0]          rs_key;

  // heap memory ports
  logic          hp_we;
  logic [SW-1:0] hp_wa, hp_ra0, hp_ra1;
  ent_t          hp_wd, rd0, rd1;
  logic [EW-1:0] rd0_raw, rd1_raw;

  // handle to slot memory
  logic [SW-1:0]          pos_mem [HANDLES];
  logic                   pos_we;
  logic [HANDLE_BITS-1:0] pos_wa, pos_ra;
  logic [SW-1:0]          pos_wd, pos_rd;

  hmq_heap_ram #(.DEPTH(CAPACITY), .WIDTH(EW), .AW(SW)) u_heap (
    .clk(clk), .we(hp_we), .wa(hp_wa), .wd(hp_wd),
    .ra0(hp_ra0), .ra1(hp_ra1), .rd0(rd0_raw), .rd1(rd1_raw)
  );
  assign rd0 = ent_t'(rd0_raw);
  assign rd1 = ent_t'(rd1_raw);

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd <= pos_mem[pos_ra];
  end

  // tree indexes around the current slot
  logic [SW-1:0] par;
  logic [IW-1:0] c1, c2;
  logic [1:0]    best;
  logic [KW-1:0] best_k;
  logic          accept;

  assign par    = SW'((p - SW'(1)) >> 1);
  assign c1     = (IW'(p) << 1) + IW'(1);
  assign c2     = c1 + IW'(1);
  assign accept = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  // smaller child wins, left child on ties, equal keys stay
  always_comb begin
    best   = 2'd0;
    best_k = cur.k;
    if (c1 < IW'(count) && rd0.k < best_k) begin
      best   = 2'd1;
      best_k = rd0.k;
    end
    if (c2 < IW'(count) && rd1.k < best_k) begin
      best = 2'd2;
    end
  end

  // memory addressing per step
  always_comb begin
    hp_ra0 = '0;
    hp_ra1 = SW'(count - CW'(1));
    hp_we  = 1'b0;
    hp_wa  = p;
    hp_wd  = cur;
    pos_ra = req.handle;
    pos_we = 1'b0;
    pos_wa = cur.h;
    pos_wd = p;
    unique case (state)
      S_RD_POS: begin
        hp_ra0 = pos_rd;
      end
      S_UP_RD: begin
        hp_ra0 = par;
      end
      S_UP_CMP: begin
        // parent moves down into the current slot
        if (rd0.k > cur.k) begin
          hp_we  = 1'b1;
          hp_wd  = rd0;
          pos_we = 1'b1;
          pos_wa = rd0.h;
        end
      end
      S_DN_RD: begin
        hp_ra0 = c1[SW-1:0];
        hp_ra1 = c2[SW-1:0];
      end
      S_DN_CMP: begin
        // chosen child moves up into the current slot
        if (best != 2'd0) begin
          hp_we  = 1'b1;
          hp_wd  = (best == 2'd1) ? rd0 : rd1;
          pos_we = 1'b1;
          pos_wa = (best == 2'd1) ? rd0.h : rd1.h;
        end
      end
      S_FINAL: begin
        hp_we  = 1'b1;
        pos_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      present    <= '0;
      res_valid  <= 1'b0;
      from_del   <= 1'b0;
      rekey_pend <= 1'b0;
    end else begin
      // response register: set when the done step hands over, cleared when taken
      if (state == S_DONE && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r    <= cmd_t'(req.command);
            h_r      <= req.handle;
            key_r    <= req.key[KW-1:0];
            from_del <= 1'b0;
            case (req.command)
              CMD_INSERT: begin
                rekey_pend <= 1'b0;
                rs_handle  <= req.handle;
                if (present[req.handle]) begin
                  rs_status <= ST_BAD;
                  rs_key    <= '0;
                  state     <= S_DONE;
                end else if (count == CW'(CAPACITY)) begin
                  rs_status <= ST_FULL;
                  rs_key    <= '0;
                  state     <= S_DONE;
                end else begin
                  rs_status            <= ST_OK;
                  cur                  <= '{h: req.handle, k: req.key[KW-1:0]};
                  p                    <= SW'(count);
                  count                <= count + CW'(1);
                  present[req.handle]  <= 1'b1;
                  rs_key               <= req.key[KW-1:0];
                  state                <= S_UP_RD;
                end
              end
              CMD_REMOVE, CMD_REKEY: begin
                rs_handle <= req.handle;
                rs_key    <= '0;
                if (count == '0) begin
                  rs_status  <= ST_EMPTY;
                  rekey_pend <= 1'b0;
                  state      <= S_DONE;
                end else if (!present[req.handle]) begin
                  rs_status  <= ST_BAD;
                  rekey_pend <= 1'b0;
                  state      <= S_DONE;
                end else begin
                  rs_status  <= ST_OK;
                  rekey_pend <= (req.command == CMD_REKEY);
                  state      <= S_RD_POS;
                end
              end
              CMD_POP, CMD_PEEK: begin
                rekey_pend <= 1'b0;
                rs_key     <= '0;
                if (count == '0) begin
                  rs_status <= ST_EMPTY;
                  rs_handle <= '0;
                  state     <= S_DONE;
                end else begin
                  rs_status <= ST_OK;
                  rs_handle <= req.handle;
                  p         <= '0;
                  state     <= S_RD_DEL;
                end
              end
              default: begin
                // unused codes: echo the handle, nothing changes
                rekey_pend <= 1'b0;
                rs_status  <= ST_OK;
                rs_handle  <= req.handle;
                rs_key     <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_RD_POS: begin
          p     <= pos_rd;
          state <= S_RD_DEL;
        end
        S_RD_DEL: begin
          if (cmd_r == CMD_PEEK) begin
            rs_handle <= rd0.h;
            rs_key    <= rd0.k;
            state     <= S_DONE;
          end else begin
            if (cmd_r == CMD_POP) begin
              rs_handle <= rd0.h;
              rs_key    <= rd0.k;
            end else if (cmd_r == CMD_REMOVE) begin
              rs_key <= rd0.k;
            end else begin
              rs_key <= key_r;
            end
            if (CW'(p) == count - CW'(1)) begin
              // hole is the last slot: nothing to refill
              if (rekey_pend) begin
                // the handle goes straight back in, starting its climb at the same slot
                cur        <= '{h: h_r, k: key_r};
                rekey_pend <= 1'b0;
                state      <= S_UP_RD;
              end else begin
                present[rd0.h] <= 1'b0;
                count          <= count - CW'(1);
                state          <= S_DONE;
              end
            end else begin
              present[rd0.h] <= 1'b0;
              count          <= count - CW'(1);
              cur            <= rd1;
              from_del       <= 1'b1;
              state          <= S_UP_RD;
            end
          end
        end
        S_UP_RD: begin
          if (p == '0) begin
            state    <= from_del ? S_DN_RD : S_FINAL;
            from_del <= 1'b0;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (rd0.k > cur.k) begin
            p     <= par;
            state <= S_UP_RD;
          end else begin
            state <= from_del ? S_DN_RD : S_FINAL;
          end
          from_del <= 1'b0;
        end
        S_DN_RD: begin
          state <= (c1 >= IW'(count)) ? S_FINAL : S_DN_CMP;
        end
        S_DN_CMP: begin
          if (best == 2'd0) begin
            state <= S_FINAL;
          end else begin
            p     <= (best == 2'd1) ? c1[SW-1:0] : c2[SW-1:0];
            state <= S_DN_RD;
          end
        end
        S_FINAL: begin
          if (rekey_pend) begin
            cur          <= '{h: h_r, k: key_r};
            p            <= SW'(count);
            count        <= count + CW'(1);
            present[h_r] <= 1'b1;
            rekey_pend   <= 1'b0;
            from_del     <= 1'b0;
            state        <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res   <= '{status: rs_status, out_handle: rs_handle,
                       out_key: 32'(rs_key), entry_count: 7'(count)};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `HMQ_ASSERT(a_count_cap, count <= CW'(CAPACITY), "entry count above capacity")
  `HMQ_ASSERT_IMP(a_present_count, state == S_IDLE,
                  $countones(present) == int'(count), "presence flags disagree with count")
  `HMQ_ASSERT_IMP(a_slot_range,
                  state == S_UP_CMP || state == S_DN_CMP || state == S_FINAL,
                  CW'(p) < count, "sift slot beyond the filled part")
  `HMQ_ASSERT_IMP(a_accept_idle, accept, state == S_IDLE, "request taken while busy")
endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// self-checking bench for indexed_min_heap_queue, one request in, one response out
// depends on hmq_pkg and the heap queue rtl; holds its own heap model for prediction
module tb_top;
  import hmq_pkg::*;

  localparam int CAP = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  always #2 clk = ~clk;

  indexed_min_heap_queue dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  // model of the heap: slot array, key per handle, slot per handle, presence
  logic [5:0]  mdl_slot [CAP];
  logic [31:0] mdl_key [64];
  int          mdl_pos [64];
  bit          mdl_live [64];
  int          mdl_count;

  req_t pending_reqs[$];
  res_t expected_res[$];
  int   mismatches = 0;
  bit   hold_for_drain = 1'b0;

  task automatic report(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic logic [31:0] key_of(input int s);
    return mdl_key[mdl_slot[s]];
  endfunction

  function automatic void place(input int s, input logic [5:0] h);
    mdl_slot[s] = h;
    mdl_pos[h] = s;
  endfunction

  function automatic void swap_at(input int a, input int b);
    logic [5:0] ha;
    ha = mdl_slot[a];
    place(a, mdl_slot[b]);
    place(b, ha);
  endfunction

  function automatic void climb(input int s);
    int p;
    while (s > 0) begin
      p = (s - 1) / 2;
      if (!(key_of(p) > key_of(s))) break;
      swap_at(p, s);
      s = p;
    end
  endfunction

  function automatic void descend(input int s);
    int best;
    int c;
    forever begin
      best = s;
      for (c = 2 * s + 1; c <= 2 * s + 2; c++)
        if (c < mdl_count && key_of(c) < key_of(best)) best = c;
      if (best == s) break;
      swap_at(s, best);
      s = best;
    end
  endfunction

  function automatic void drop_slot(input int s);
    mdl_live[mdl_slot[s]] = 1'b0;
    mdl_count--;
    if (s != mdl_count) begin
      place(s, mdl_slot[mdl_count]);
      // the moved entry may belong above or below the hole
      if (s > 0 && key_of((s - 1) / 2) > key_of(s)) climb(s);
      else descend(s);
    end
  endfunction

  function automatic void add(input logic [5:0] h, input logic [31:0] k);
    mdl_key[h] = k;
    mdl_live[h] = 1'b1;
    place(mdl_count, h);
    mdl_count++;
    climb(mdl_count - 1);
  endfunction

  function automatic res_t heap_predict(input req_t r);
    res_t o;
    logic [31:0] old;
    o = '0;
    o.status = ST_OK;
    o.out_handle = r.handle;
    case (r.command)
      CMD_INSERT: begin
        if (mdl_live[r.handle]) o.status = ST_BAD;
        else if (mdl_count >= CAP) o.status = ST_FULL;
        else begin
          add(r.handle, r.key);
          o.out_key = r.key;
        end
      end
      CMD_REMOVE, CMD_REKEY: begin
        if (mdl_count == 0) o.status = ST_EMPTY;
        else if (!mdl_live[r.handle]) o.status = ST_BAD;
        else begin
          old = mdl_key[r.handle];
          drop_slot(mdl_pos[r.handle]);
          if (r.command == CMD_REKEY) begin
            add(r.handle, r.key);
            o.out_key = r.key;
          end else o.out_key = old;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (mdl_count == 0) begin
          o.status = ST_EMPTY;
          o.out_handle = '0;
        end else begin
          o.out_handle = mdl_slot[0];
          o.out_key = mdl_key[mdl_slot[0]];
          if (r.command == CMD_POP) drop_slot(0);
        end
      end
      default: ;
    endcase
    o.entry_count = 7'(mdl_count);
    return o;
  endfunction

  // driver: bursts of requests with random gaps, predicts on acceptance
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_res.push_back(heap_predict(req));
        void'(pending_reqs.pop_front());
      end
      if (req_valid && req_stall) begin
        // stalled request holds
      end else if (hold_for_drain) begin
        req_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_valid <= 1'b1;
        req <= pending_reqs[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end else burst_left <= burst_left - 1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: alternating calm and choppy stretches
  int stall_phase = 0;
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 120) res_stall <= 1'b0;
    else if (stall_phase < 300) res_stall <= ($urandom_range(0, 2) == 0);
    else res_stall <= ($urandom_range(0, 5) != 0);
  end

  // monitor: compare each accepted response with the oldest prediction
  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected_res.size() == 0) report("response with none expected");
      else begin
        e = expected_res.pop_front();
        if (res.status !== e.status)
          report($sformatf("status %0d want %0d", res.status, e.status));
        if (res.out_handle !== e.out_handle)
          report($sformatf("handle %0d want %0d", res.out_handle, e.out_handle));
        if (res.out_key !== e.out_key)
          report($sformatf("key %h want %h", res.out_key, e.out_key));
        if (res.entry_count !== e.entry_count)
          report($sformatf("count %0d want %0d", res.entry_count, e.entry_count));
      end
    end
  end

  function automatic req_t mk(input cmd_t c, input logic [5:0] h, input logic [31:0] k);
    req_t r;
    r.command = c;
    r.handle = h;
    r.key = k;
    return r;
  endfunction

  // random handle biased toward a small pool so removes and rekeys hit often
  function automatic logic [5:0] pick_handle();
    return ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 7);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    // directed: empty-heap errors, extremes, ties, duplicates, unused codes
    pending_reqs.push_back(mk(CMD_POP, 6'd5, 32'd0));
    pending_reqs.push_back(mk(CMD_PEEK, 6'd0, 32'd0));
    pending_reqs.push_back(mk(CMD_REMOVE, 6'd63, 32'd0));
    pending_reqs.push_back(mk(CMD_REKEY, 6'd1, 32'd9));
    pending_reqs.push_back(mk(CMD_INSERT, 6'd63, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk(CMD_INSERT, 6'd0, 32'd0));
    pending_reqs.push_back(mk(CMD_INSERT, 6'd0, 32'd7));
    pending_reqs.push_back(mk(CMD_INSERT, 6'd10, 32'd0));
    pending_reqs.push_back(mk(CMD_INSERT, 6'd11, 32'd0));
    pending_reqs.push_back(mk(CMD_REMOVE, 6'd20, 32'd0));
    pending_reqs.push_back(mk(CMD_PEEK, 6'd0, 32'd0));
    pending_reqs.push_back(mk(CMD_REKEY, 6'd63, 32'd1));
    pending_reqs.push_back(mk(CMD_REMOVE, 6'd0, 32'd0));
    pending_reqs.push_back(mk(CMD_POP, 6'd0, 32'd0));
    pending_reqs.push_back(req_t'({3'd5, 6'd42, 32'hAAAA_5555}));
    pending_reqs.push_back(req_t'({3'd6, 6'd21, 32'h5555_AAAA}));
    pending_reqs.push_back(req_t'({3'd7, 6'd63, 32'hFFFF_FFFF}));
    for (n = 0; n < 3; n++) pending_reqs.push_back(mk(CMD_POP, 6'd0, 32'd0));
    // fill to capacity, then insert again with a handle already in use
    for (n = 0; n < 64; n++) pending_reqs.push_back(mk(CMD_INSERT, 6'(n), $urandom));
    pending_reqs.push_back(mk(CMD_INSERT, 6'd3, 32'd1));
  end

  initial begin
    int n;
    int w;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    // pause until everything has drained once
    hold_for_drain = 1'b1;
    wait (expected_res.size() == 0 && !req_valid);
    hold_for_drain = 1'b0;
    // random: mostly well-formed mixes, drift between filling and draining
    for (n = 0; n < 1500; n++) begin
      w = $urandom_range(0, 99);
      if (((n / 200) % 2 == 0 && w < 45) || w < 25)
        pending_reqs.push_back(mk(CMD_INSERT, pick_handle(), pick_key()));
      else if (w < 60) pending_reqs.push_back(mk(CMD_POP, 6'($urandom), 32'($urandom)));
      else if (w < 72) pending_reqs.push_back(mk(CMD_REMOVE, pick_handle(), 32'($urandom)));
      else if (w < 86) pending_reqs.push_back(mk(CMD_REKEY, pick_handle(), pick_key()));
      else if (w < 97) pending_reqs.push_back(mk(CMD_PEEK, 6'($urandom), 32'($urandom)));
      else pending_reqs.push_back(req_t'({3'($urandom_range(5, 7)), 6'($urandom), 32'($urandom)}));
    end
    wait (pending_reqs.size() == 0 && !req_valid);
    wait (expected_res.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
